// File: rtl/bogv_pkg.sv
// Shared types, constants and helpers for the box occlusion grid visibility block.
// Used by bogv_grid, bogv_emit and box_occlusion_grid_visibility; depends on nothing.
`default_nettype none

package bogv_pkg;

  // Grid geometry
  localparam int GRID_DIVISIONS = 8;
  localparam int GRID_CELLS     = GRID_DIVISIONS * GRID_DIVISIONS;
  localparam int ROW_CNT_W      = $clog2(GRID_DIVISIONS + 1);

  // Field widths
  localparam int COORD_IN_W = 19;
  localparam int LEN_W      = 18;
  localparam int KIND_W     = 2;
  localparam int MASK_W     = 64;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 1;

  // Stream payload widths (whole bytes)
  localparam int S_TDATA_W = 80;
  localparam int M_TDATA_W = 72;

  // Scaled coordinate width: 2*G*coordinate plus (2G-1)*length, with headroom
  localparam int COORD_W = 26;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OCCLUDE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMIT    = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_W = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_H = 1'd1;

  // Register reset values
  localparam logic [LEN_W-1:0] FRAME_W_RESET = 18'd10240;
  localparam logic [LEN_W-1:0] FRAME_H_RESET = 18'd7680;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic [ROW_CNT_W-1:0]       row_cnt_t;

  // One box as it sits in tdata, left edge in the lowest bits
  typedef struct packed {
    logic [LEN_W-1:0]             box_height;
    logic [LEN_W-1:0]             box_width;
    logic signed [COORD_IN_W-1:0] box_bottom;
    logic signed [COORD_IN_W-1:0] box_left;
  } box_t;

  // Per-item control from the input stage to the grid
  typedef struct packed {
    logic load;
    logic occlude;
  } grid_ctl_t;

  // Widen a signed edge coordinate
  function automatic coord_t coord_s(input logic signed [COORD_IN_W-1:0] v);
    coord_t r;
    r = coord_t'(v);
    return r;
  endfunction

  // Widen an unsigned length
  function automatic coord_t coord_u(input logic [LEN_W-1:0] v);
    coord_t r;
    r = coord_t'({1'b0, v});
    return r;
  endfunction

  // Count set bits of one grid row
  function automatic row_cnt_t row_count(input logic [GRID_DIVISIONS-1:0] v);
    row_cnt_t c;
    c = '0;
    for (int i = 0; i < GRID_DIVISIONS; i++) begin
      c = c + row_cnt_t'(v[i]);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/box_occlusion_grid_visibility.sv
// Box occlusion grid visibility: top level with input register and configuration.
// Instantiates bogv_grid and bogv_emit; depends on bogv_pkg.
//
// Use:
//   s_* carries one item per handshake: s_tuser is the kind (0 load target,
//   1 occluder, 2 emit, 3 ignored), s_tdata the box. An item may be taken in
//   every cycle. In the input register the 64 cell tests run in parallel
//   against the stored scaled cell centres (the new ones for a load target)
//   and update the occlusion mask as the item leaves the input register.
//   m_* carries one result for each kind 2 item: the visibility mask and the
//   visible count. The result register loads as the emit item leaves the
//   input register and raises m_tvalid.
//   cfg_* writes the image width (index 0) or height (index 1); it is always
//   ready and must be used only while the block is idle.
//   Throughput is one item per cycle. While a result waits on m_tready, load
//   and occluder items still pass; a further emit item holds in the input
//   register and s_tready stays low until the waiting result is taken.
//   Reset clears the target to zero, marks every cell visible, restores the
//   image size to 10240 by 7680 units and empties both registers.
`default_nettype none

module box_occlusion_grid_visibility (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // box_left[18:0], box_bottom[37:19], box_width[55:38], box_height[73:56], zeros
  input  wire logic [bogv_pkg::S_TDATA_W-1:0]       s_tdata,
  // kind[1:0]
  input  wire logic [bogv_pkg::KIND_W-1:0]          s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // visible_mask[63:0], visible_count[70:64], zero[71]
  output logic [bogv_pkg::M_TDATA_W-1:0]            m_tdata,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [bogv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [bogv_pkg::LEN_W-1:0]           cfg_data
);
  import bogv_pkg::*;

  logic                a_valid;
  logic [KIND_W-1:0]   a_kind;
  box_t                a_box;
  logic                advance;
  grid_ctl_t           ctl;
  logic [LEN_W-1:0]    frame_w, frame_h;
  logic [GRID_CELLS-1:0] occluded;
  row_cnt_t            vis_rows [GRID_DIVISIONS];
  logic [MASK_W-1:0]   mask;
  logic [COUNT_W-1:0]  count;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= FRAME_W_RESET;
      frame_h <= FRAME_H_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_W: frame_w <= cfg_data;
        REG_FRAME_H: frame_h <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance unless an emit item would overwrite a waiting result
  assign advance  = a_valid && ((a_kind != KIND_EMIT) || !m_tvalid || m_tready);
  assign s_tready = !a_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_kind <= s_tuser;
      a_box  <= box_t'(s_tdata[$bits(box_t)-1:0]);
    end
  end

  // Decode the item kind
  always_comb begin
    ctl.load    = advance && (a_kind == KIND_LOAD);
    ctl.occlude = advance && (a_kind == KIND_OCCLUDE);
  end

  bogv_grid u_grid (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .box      (a_box),
    .frame_w  (frame_w),
    .frame_h  (frame_h),
    .occluded (occluded),
    .vis_rows (vis_rows)
  );

  bogv_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .emit     (advance && (a_kind == KIND_EMIT)),
    .ready    (m_tready),
    .occluded (occluded),
    .vis_rows (vis_rows),
    .valid    (m_tvalid),
    .mask     (mask),
    .count    (count)
  );

  assign m_tdata = {{(M_TDATA_W - MASK_W - COUNT_W){1'b0}}, count, mask};

endmodule

`default_nettype wire

// File: rtl/bogv_grid.sv
// Cell-centre store and per-cell containment tests for the visibility grid.
// Holds the occlusion mask and per-row visible counts; depends on bogv_pkg.
`default_nettype none

module bogv_grid (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire bogv_pkg::grid_ctl_t                  ctl,
  input  wire bogv_pkg::box_t                       box,
  input  wire logic [bogv_pkg::LEN_W-1:0]           frame_w,
  input  wire logic [bogv_pkg::LEN_W-1:0]           frame_h,
  output logic [bogv_pkg::GRID_CELLS-1:0]           occluded,
  output bogv_pkg::row_cnt_t                        vis_rows [bogv_pkg::GRID_DIVISIONS]
);
  import bogv_pkg::*;

  coord_t cx [GRID_DIVISIONS];
  coord_t cy [GRID_DIVISIONS];
  coord_t cx_next [GRID_DIVISIONS];
  coord_t cy_next [GRID_DIVISIONS];
  coord_t half_x, half_y;
  coord_t lo_x, hi_x, lo_y, hi_y;
  logic [GRID_DIVISIONS-1:0] img_x, img_y, hit_x, hit_y;
  logic [GRID_CELLS-1:0] img_out, occ_hit, occluded_next;
  row_cnt_t vis_rows_next [GRID_DIVISIONS];

  // Scaled centres of a newly loaded target
  always_comb begin
    for (int i = 0; i < GRID_DIVISIONS; i++) begin
      cx_next[i] = coord_s(box.box_left) * coord_t'(2 * GRID_DIVISIONS)
                   + coord_u(box.box_width) * coord_t'(2 * i + 1);
      cy_next[i] = coord_s(box.box_bottom) * coord_t'(2 * GRID_DIVISIONS)
                   + coord_u(box.box_height) * coord_t'(2 * i + 1);
    end
  end

  // Image bounds and occluder bounds, all scaled by 2G
  always_comb begin
    half_x = coord_u(frame_w) * coord_t'(GRID_DIVISIONS);
    half_y = coord_u(frame_h) * coord_t'(GRID_DIVISIONS);
    lo_x   = coord_s(box.box_left) * coord_t'(2 * GRID_DIVISIONS);
    hi_x   = (coord_s(box.box_left) + coord_u(box.box_width)) * coord_t'(2 * GRID_DIVISIONS);
    lo_y   = coord_s(box.box_bottom) * coord_t'(2 * GRID_DIVISIONS);
    hi_y   = (coord_s(box.box_bottom) + coord_u(box.box_height))
             * coord_t'(2 * GRID_DIVISIONS);
  end

  // Per-axis tests, inclusive bounds
  always_comb begin
    for (int i = 0; i < GRID_DIVISIONS; i++) begin
      img_x[i] = (cx_next[i] >= -half_x) && (cx_next[i] <= half_x);
      img_y[i] = (cy_next[i] >= -half_y) && (cy_next[i] <= half_y);
      hit_x[i] = (cx[i] >= lo_x) && (cx[i] <= hi_x);
      hit_y[i] = (cy[i] >= lo_y) && (cy[i] <= hi_y);
    end
  end

  // Combine axes into cell masks, cell x*G+y
  always_comb begin
    for (int x = 0; x < GRID_DIVISIONS; x++) begin
      for (int y = 0; y < GRID_DIVISIONS; y++) begin
        img_out[x * GRID_DIVISIONS + y] = !(img_x[x] && img_y[y]);
        occ_hit[x * GRID_DIVISIONS + y] = hit_x[x] && hit_y[y];
      end
    end
  end

  // Next mask and its per-row visible counts
  always_comb begin
    occluded_next = occluded;
    if (ctl.load) begin
      occluded_next = img_out;
    end else if (ctl.occlude) begin
      occluded_next = occluded | occ_hit;
    end
    for (int x = 0; x < GRID_DIVISIONS; x++) begin
      vis_rows_next[x] = row_count(~occluded_next[x * GRID_DIVISIONS +: GRID_DIVISIONS]);
    end
  end

  // Hold centres, mask and counts
  always_ff @(posedge clk) begin
    if (rst) begin
      occluded <= '0;
      for (int i = 0; i < GRID_DIVISIONS; i++) begin
        cx[i]       <= '0;
        cy[i]       <= '0;
        vis_rows[i] <= row_cnt_t'(GRID_DIVISIONS);
      end
    end else begin
      occluded <= occluded_next;
      for (int i = 0; i < GRID_DIVISIONS; i++) begin
        vis_rows[i] <= vis_rows_next[i];
      end
      if (ctl.load) begin
        for (int i = 0; i < GRID_DIVISIONS; i++) begin
          cx[i] <= cx_next[i];
          cy[i] <= cy_next[i];
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bogv_emit.sv
// Result register for the visibility mask and visible count.
// Sums the per-row counts kept by bogv_grid; depends on bogv_pkg.
`default_nettype none

module bogv_emit (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 emit,
  input  wire logic                                 ready,
  input  wire logic [bogv_pkg::GRID_CELLS-1:0]      occluded,
  input  wire bogv_pkg::row_cnt_t                   vis_rows [bogv_pkg::GRID_DIVISIONS],
  output logic                                      valid,
  output logic [bogv_pkg::MASK_W-1:0]               mask,
  output logic [bogv_pkg::COUNT_W-1:0]              count
);
  import bogv_pkg::*;

  logic [COUNT_W-1:0] count_next;

  // Add up the row counts
  always_comb begin
    count_next = '0;
    for (int i = 0; i < GRID_DIVISIONS; i++) begin
      count_next = count_next + COUNT_W'(vis_rows[i]);
    end
  end

  // Result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (emit) begin
      valid <= 1'b1;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      mask  <= MASK_W'(~occluded);
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    valid |-> (count == COUNT_W'($countones(mask))))
    else $error("visible count does not match mask");

  a_mask_in_grid: assert property (@(posedge clk) disable iff (rst)
    valid |-> ((mask >> GRID_CELLS) == '0))
    else $error("mask bit set outside the grid");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
